### hdl/bounded_ordered_list_engine_unit_macros.svh
// Assertion macros of the ordered list engine RTL.
// Used by bole_ctrl, the file that carries concurrent checks; no other dependencies.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define BOLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define BOLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bole_pkg.sv
// Shared constants, codes and types of the ordered list engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package bole_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd5;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } bole_status_e;

  // Storage port request from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } bole_mem_req_t;

  // Finished result handed to the output stage
  typedef struct packed {
    logic               done;
    bole_status_e       status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } bole_res_t;

endpackage

`default_nettype wire

### hdl/bole_mem.sv
// List storage: one write port, one registered read port.
// Depends on bole_pkg for widths and the request struct.
`default_nettype none

module bole_mem import bole_pkg::*; (
  input  logic              clk_i,
  input  bole_mem_req_t     req_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;

  // Write and registered read; a read of an address written in the same cycle returns the old entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/bole_ctrl.sv
// Command sequencer: decodes a command, walks the stored entries one per
// cycle through the storage port, shifts or compares. Uses bole_pkg.
`default_nettype none

module bole_ctrl import bole_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     take_i,
  output logic                     idle_o,
  output bole_res_t                res_o,
  output bole_mem_req_t            mem_req_o,
  input  logic [DATA_W-1:0]        rd_data_i
);

  `include "bounded_ordered_list_engine_unit_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               up_q, up_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   la_q, la_d;
  logic               found_q, found_d;
  bole_status_e       status_q, status_d;
  logic [CMP_W-1:0]   ins_pos;
  logic               is_ins;

  // Insert position for the three insert flavors
  always_comb begin
    case (cmd_i)
      CMD_INS_END: ins_pos = CMP_W'(cnt_q);
      CMD_INS_POS: ins_pos = CMP_W'(position_i);
      default:     ins_pos = '0;
    endcase
  end

  assign is_ins = (cmd_q == CMD_INS_FRONT) || (cmd_q == CMD_INS_END) ||
                  (cmd_q == CMD_INS_POS);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    rem_d     = rem_q;
    up_d      = up_q;
    pend_d    = pend_q;
    la_d      = la_q;
    found_d   = found_q;
    status_d  = status_q;
    mem_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          val_d    = value_i;
          found_d  = 1'b0;
          status_d = ST_OK;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          case (cmd_i)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
              end else if (ins_pos > CMP_W'(cnt_q)) begin
                status_d = ST_BADPOS;
              end else begin
                // shift entries pos..cnt-1 up by one, top first
                pos_d   = IDX_W'(ins_pos);
                rem_d   = cnt_q - CNT_W'(ins_pos);
                k_d     = IDX_W'(cnt_q - CNT_W'(1));
                up_d    = 1'b0;
                state_d = S_WALK;
              end
            end
            CMD_DEL_FRONT: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // shift entries 1..cnt-1 down by one
                rem_d   = cnt_q - CNT_W'(1);
                k_d     = IDX_W'(1);
                up_d    = 1'b1;
                state_d = S_WALK;
              end
            end
            CMD_DEL_END: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CNT_W'(1);
              end
            end
            CMD_SEARCH: begin
              rem_d   = cnt_q;
              k_d     = '0;
              up_d    = 1'b1;
              state_d = S_WALK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        // issue the next read
        if (rem_q != '0) begin
          mem_req_o.raddr = k_q;
          k_d    = up_q ? k_q + IDX_W'(1) : k_q - IDX_W'(1);
          rem_d  = rem_q - CNT_W'(1);
          pend_d = 1'b1;
          la_d   = k_q;
        end else begin
          pend_d = 1'b0;
        end
        // consume read data from the previous cycle
        if (pend_q) begin
          if (cmd_q == CMD_SEARCH) begin
            if (rd_data_i == val_q) begin
              found_d = 1'b1;
            end
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = up_q ? la_q - IDX_W'(1) : la_q + IDX_W'(1);
            mem_req_o.wdata = rd_data_i;
          end
        end
        // walk finished: store the new value or adjust the count
        if ((rem_q == '0) && !pend_q) begin
          state_d = S_DONE;
          if (is_ins) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = pos_q;
            mem_req_o.wdata = val_q;
            cnt_d           = cnt_q + CNT_W'(1);
          end else if (cmd_q == CMD_DEL_FRONT) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      cmd_q    <= '0;
      val_q    <= '0;
      pos_q    <= '0;
      k_q      <= '0;
      rem_q    <= '0;
      up_q     <= 1'b0;
      la_q     <= '0;
      found_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      cmd_q    <= cmd_d;
      val_q    <= val_d;
      pos_q    <= pos_d;
      k_q      <= k_d;
      rem_q    <= rem_d;
      up_q     <= up_d;
      la_q     <= la_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  assign idle_o       = (state_q == S_IDLE);
  assign res_o.done   = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.found  = found_q;
  assign res_o.count  = COUNT_W'(cnt_q);

  // Checks
  `BOLE_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
  `BOLE_ASSERT_NOW(a_we_walk, clk_i, rst_ni, mem_req_o.we, state_q == S_WALK, "write outside walk")
  `BOLE_ASSERT_NOW(a_we_range, clk_i, rst_ni, mem_req_o.we, CNT_W'(mem_req_o.waddr) <= cnt_q, "write beyond list end")
  `BOLE_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && idle_o, !idle_o, "idle right after a command")

endmodule

`default_nettype wire

### hdl/bounded_ordered_list_engine_unit.sv
// Top level of the ordered list engine: sequencer, list storage and the
// output register. Depends on bole_pkg, bole_ctrl and bole_mem.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid_i/in_ready_o | cmd_i, value_i, position_i
//   out     | output    | out_valid_o/out_ready_i | status_o, found_o, count_o
//
// A command that touches no entry (refused insert, delete from empty, delete
// end, unused code) goes straight from idle to done; any other command walks
// n entries: count - position for inserts, count - 1 for delete front, count
// for search. The walk reads through the single storage read port and then
// drains the last read. in_ready_o is high only while the sequencer is idle;
// a finished result waits in the sequencer while the output register is full
// and not being drained. Reset empties the list.
`default_nettype none

module bounded_ordered_list_engine_unit import bole_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic                     found_o,
  output logic [COUNT_W-1:0]       count_o
);

  bole_res_t          res;
  bole_mem_req_t      mem_req;
  logic [DATA_W-1:0]  rd_data;
  logic               idle;
  logic               take;
  logic               out_valid_q;
  bole_status_e       status_q;
  logic               found_q;
  logic [COUNT_W-1:0] count_q;

  assign take       = !out_valid_q || out_ready_i;
  assign in_ready_o = idle;

  bole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .position_i (position_i),
    .take_i     (take),
    .idle_o     (idle),
    .res_o      (res),
    .mem_req_o  (mem_req),
    .rd_data_i  (rd_data)
  );

  bole_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: loads a finished result when free or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      found_q     <= 1'b0;
      count_q     <= '0;
    end else begin
      if (res.done && take) begin
        out_valid_q <= 1'b1;
        status_q    <= res.status;
        found_q     <= res.found;
        count_q     <= res.count;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign count_o     = count_q;

endmodule

`default_nettype wire
